FILE: rtl/msbs_pkg.sv
// ----------------------------------------------------------------------------
// msbs_pkg
// shared types and codes of the multi-stream barrier synchronizer
// ----------------------------------------------------------------------------
package msbs_pkg;

    localparam int NOZZLES    = 4;
    localparam int NOZ_W      = 2;
    localparam int PAY_W      = 32;
    localparam int ID_W       = 8;
    localparam int TASK_IDS   = 256;
    localparam int KIND_W     = 3;
    localparam int CFG_W      = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [KIND_W-1:0] K_REGULAR = 3'd0;
    localparam logic [KIND_W-1:0] K_BARRIER = 3'd1;
    localparam logic [KIND_W-1:0] K_WAIT    = 3'd2;
    localparam logic [KIND_W-1:0] K_BEGIN   = 3'd3;
    localparam logic [KIND_W-1:0] K_TEND    = 3'd4;
    localparam logic [KIND_W-1:0] K_EOS     = 3'd5;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_BAR  = 2'd1;
    localparam logic [1:0] ST_TASK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_PULL = 3'd1;
    localparam logic [2:0] OP_REG  = 3'd2;
    localparam logic [2:0] OP_BAR  = 3'd3;
    localparam logic [2:0] OP_WAIT = 3'd4;
    localparam logic [2:0] OP_TEND = 3'd5;
    localparam logic [2:0] OP_EOS  = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [NOZ_W-1:0] nozzle;
        logic [ID_W-1:0]  sync_id;
        logic [PAY_W-1:0] payload;
    } t_op_word;

    typedef struct packed {
        logic             yield_valid;
        logic [NOZ_W-1:0] yield_nozzle;
        logic [PAY_W-1:0] yield_payload;
        logic [NOZZLES-1:0] want_mask;
        logic             all_done;
        logic             feed_rejected;
    } t_result;

endpackage

FILE: rtl/msbs_fifo.sv
// ----------------------------------------------------------------------------
// msbs_fifo
// short word queue, push and pop in the same cycle
// ----------------------------------------------------------------------------
module msbs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int DEPTH = msbs_pkg::FIFO_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: rtl/msbs_front.sv
// ----------------------------------------------------------------------------
// msbs_front
// accepts input words, decodes them into operations and queues them
// ----------------------------------------------------------------------------
module msbs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_hold,
    input  logic                          i_cmd,
    input  logic [msbs_pkg::NOZ_W-1:0]    i_nozzle,
    input  logic [msbs_pkg::KIND_W-1:0]   i_element_kind,
    input  logic [msbs_pkg::ID_W-1:0]     i_sync_id,
    input  logic [msbs_pkg::PAY_W-1:0]    i_payload,
    output msbs_pkg::t_op_word            o_head,
    output logic                          o_empty,
    input  logic                          i_pop
);

    msbs_pkg::t_op_word op_word;
    logic               q_full;
    logic [$bits(msbs_pkg::t_op_word)-1:0] q_rdata;

    always_comb begin
        op_word.nozzle  = i_nozzle;
        op_word.sync_id = i_sync_id;
        op_word.payload = i_payload;
        if (i_cmd == msbs_pkg::CMD_PULL) begin
            op_word.op = msbs_pkg::OP_PULL;
        end else begin
            unique case (i_element_kind)
                msbs_pkg::K_REGULAR: op_word.op = msbs_pkg::OP_REG;
                msbs_pkg::K_BARRIER: op_word.op = msbs_pkg::OP_BAR;
                msbs_pkg::K_WAIT:    op_word.op = msbs_pkg::OP_WAIT;
                msbs_pkg::K_TEND:    op_word.op = msbs_pkg::OP_TEND;
                msbs_pkg::K_EOS:     op_word.op = msbs_pkg::OP_EOS;
                default:             op_word.op = msbs_pkg::OP_NOP;
            endcase
        end
    end

    assign o_full = q_full || i_hold;
    assign o_head = msbs_pkg::t_op_word'(q_rdata);

    msbs_fifo #(
        .WIDTH($bits(msbs_pkg::t_op_word))
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_wdata (op_word),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_rdata (q_rdata),
        .o_empty (o_empty)
    );

endmodule

FILE: rtl/msbs_exec.sv
// ----------------------------------------------------------------------------
// msbs_exec
// nozzle state, completed task map, release rules and result queue
// ----------------------------------------------------------------------------
module msbs_exec (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [msbs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  msbs_pkg::t_op_word           i_head,
    input  logic                         i_head_empty,
    output logic                         o_head_pop,
    output logic                         o_busy,
    output msbs_pkg::t_result            o_result,
    output logic                         o_empty,
    input  logic                         i_pop
);

    localparam int N  = msbs_pkg::NOZZLES;
    localparam int NW = msbs_pkg::NOZ_W;
    localparam int IW = msbs_pkg::ID_W;
    localparam int PW = msbs_pkg::PAY_W;
    localparam int CW = msbs_pkg::CFG_W;

    logic [CW-1:0] r_active;
    logic [CW-1:0] live_cnt;
    logic [N-1:0]  act;

    logic [1:0]    r_status   [N];
    logic [1:0]    n_status   [N];
    logic [N-1:0]  r_pend_v, n_pend_v;
    logic [PW-1:0] r_pend_w   [N];
    logic [PW-1:0] n_pend_w   [N];
    logic [IW-1:0] r_bar      [N];
    logic [IW-1:0] n_bar      [N];
    logic [IW-1:0] r_blk_task [N];
    logic [IW-1:0] n_blk_task [N];
    logic [N-1:0]  r_met, n_met;

    logic          r_task_map [msbs_pkg::TASK_IDS];
    logic          r_map_rd;
    logic          r_fwd_hit;
    logic          r_clr_busy;
    logic [IW-1:0] r_clr_addr;
    logic          map_we;
    logic [IW-1:0] map_wa;
    logic          map_wd;
    logic          map_bit;

    logic                r_ex_valid;
    msbs_pkg::t_op_word  r_ex;
    logic                adv, load, fire;
    logic                out_full;
    logic [$bits(msbs_pkg::t_result)-1:0] out_rdata;

    logic                is_feed, rej, tend_apply;
    logic [N-1:0]        wants;
    logic                pull_hit;
    logic [NW-1:0]       pull_idx;
    logic                bar_found, bar_all;
    logic [IW-1:0]       bid;
    msbs_pkg::t_result   res;

    assign live_cnt = (r_active == '0) ? CW'(1) :
                      (r_active > CW'(N)) ? CW'(N) : r_active;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            act[i]   = CW'(i) < live_cnt;
            wants[i] = act[i] && (r_status[i] == msbs_pkg::ST_RUN) && !r_pend_v[i];
        end
    end

    assign adv        = !r_ex_valid || !out_full;
    assign load       = adv && !i_head_empty;
    assign fire       = r_ex_valid && !out_full;
    assign o_head_pop = load;
    assign o_busy     = r_clr_busy;

    assign is_feed    = (r_ex.op != msbs_pkg::OP_PULL);
    assign rej        = is_feed && !wants[r_ex.nozzle];
    assign tend_apply = is_feed && !rej && (r_ex.op == msbs_pkg::OP_TEND);
    assign map_bit    = r_map_rd || r_fwd_hit;

    // one step of the stream model
    always_comb begin
        n_status   = r_status;
        n_pend_v   = r_pend_v;
        n_pend_w   = r_pend_w;
        n_bar      = r_bar;
        n_blk_task = r_blk_task;
        n_met      = r_met;
        pull_hit   = 1'b0;
        pull_idx   = '0;
        bar_found  = 1'b0;
        bar_all    = 1'b1;
        bid        = '0;
        res        = '0;

        if (is_feed && !rej) begin
            unique case (r_ex.op)
                msbs_pkg::OP_REG: begin
                    n_pend_v[r_ex.nozzle] = 1'b1;
                    n_pend_w[r_ex.nozzle] = r_ex.payload;
                end
                msbs_pkg::OP_BAR: begin
                    n_status[r_ex.nozzle] = msbs_pkg::ST_BAR;
                    n_bar[r_ex.nozzle]    = r_ex.sync_id;
                end
                msbs_pkg::OP_WAIT: begin
                    if (!map_bit) begin
                        n_status[r_ex.nozzle]   = msbs_pkg::ST_TASK;
                        n_blk_task[r_ex.nozzle] = r_ex.sync_id;
                        n_met[r_ex.nozzle]      = 1'b0;
                    end
                end
                msbs_pkg::OP_EOS: begin
                    n_status[r_ex.nozzle] = msbs_pkg::ST_DONE;
                end
                default: begin
                end
            endcase
        end

        if (!is_feed) begin
            for (int i = 0; i < N; i++) begin
                if (!pull_hit && act[i] && (r_status[i] == msbs_pkg::ST_RUN) &&
                    r_pend_v[i]) begin
                    pull_hit = 1'b1;
                    pull_idx = NW'(i);
                end
            end
            if (pull_hit) begin
                n_pend_v[pull_idx] = 1'b0;
            end
        end

        // barrier release
        for (int i = 0; i < N; i++) begin
            if (!bar_found && act[i] && (n_status[i] == msbs_pkg::ST_BAR)) begin
                bar_found = 1'b1;
                bid       = n_bar[i];
            end
        end
        for (int i = 0; i < N; i++) begin
            if (act[i] && (n_status[i] != msbs_pkg::ST_DONE) &&
                !((n_status[i] == msbs_pkg::ST_BAR) && (n_bar[i] == bid))) begin
                bar_all = 1'b0;
            end
        end
        if (bar_found && bar_all) begin
            for (int i = 0; i < N; i++) begin
                if (act[i] && (n_status[i] == msbs_pkg::ST_BAR) && (n_bar[i] == bid)) begin
                    n_status[i] = msbs_pkg::ST_RUN;
                    n_bar[i]    = '0;
                end
            end
        end

        // task release
        for (int i = 0; i < N; i++) begin
            if (tend_apply && (n_status[i] == msbs_pkg::ST_TASK) &&
                (n_blk_task[i] == r_ex.sync_id)) begin
                n_met[i] = 1'b1;
            end
            if (act[i] && (n_status[i] == msbs_pkg::ST_TASK) && n_met[i]) begin
                n_status[i]   = msbs_pkg::ST_RUN;
                n_blk_task[i] = '0;
                n_met[i]      = 1'b0;
            end
        end

        res.yield_valid   = pull_hit;
        res.yield_nozzle  = pull_hit ? pull_idx : '0;
        res.yield_payload = pull_hit ? r_pend_w[pull_idx] : '0;
        res.feed_rejected = rej;
        res.all_done      = 1'b1;
        for (int i = 0; i < N; i++) begin
            res.want_mask[i] = act[i] && (n_status[i] == msbs_pkg::ST_RUN) && !n_pend_v[i];
            if (act[i] && (n_status[i] != msbs_pkg::ST_DONE)) begin
                res.all_done = 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            map_we = 1'b1;
            map_wa = r_clr_addr;
            map_wd = 1'b0;
        end else begin
            map_we = fire && tend_apply;
            map_wa = r_ex.sync_id;
            map_wd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= msbs_pkg::CFG_RESET;
            r_pend_v   <= '0;
            r_met      <= '0;
            r_ex_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            for (int i = 0; i < N; i++) begin
                r_status[i]   <= msbs_pkg::ST_RUN;
                r_bar[i]      <= '0;
                r_blk_task[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(msbs_pkg::TASK_IDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (fire) begin
                r_status   <= n_status;
                r_pend_v   <= n_pend_v;
                r_bar      <= n_bar;
                r_blk_task <= n_blk_task;
                r_met      <= n_met;
            end
            if (adv) begin
                r_ex_valid <= !i_head_empty;
            end
            if (load) begin
                r_fwd_hit <= fire && tend_apply && (r_ex.sync_id == i_head.sync_id);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_w <= n_pend_w;
        end
        if (load) begin
            r_ex     <= i_head;
            r_map_rd <= r_task_map[i_head.sync_id];
        end
        if (map_we) begin
            r_task_map[map_wa] <= map_wd;
        end
    end

    assign o_result = msbs_pkg::t_result'(out_rdata);

    msbs_fifo #(
        .WIDTH($bits(msbs_pkg::t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_wdata (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_rdata (out_rdata),
        .o_empty (o_empty)
    );

endmodule

FILE: rtl/multi_stream_barrier_sync.sv
// ----------------------------------------------------------------------------
// multi_stream_barrier_sync
// path: a word passes front queue, execute register, result queue to the output
// throughput: one word per cycle unless stalled; both queues decouple stalls
// reset: after reset the 256 completed task map entries are cleared, full high
// reset: all nozzles running, nothing buffered, active nozzle count 4
// ----------------------------------------------------------------------------
module multi_stream_barrier_sync (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd,
    input  logic [msbs_pkg::NOZ_W-1:0]    i_nozzle,
    input  logic [msbs_pkg::KIND_W-1:0]   i_element_kind,
    input  logic [msbs_pkg::ID_W-1:0]     i_sync_id,
    input  logic [msbs_pkg::PAY_W-1:0]    i_payload,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_yield_valid,
    output logic [msbs_pkg::NOZ_W-1:0]    o_yield_nozzle,
    output logic [msbs_pkg::PAY_W-1:0]    o_yield_payload,
    output logic [msbs_pkg::NOZZLES-1:0]  o_want_mask,
    output logic                          o_all_done,
    output logic                          o_feed_rejected,
    input  logic                          i_cfg_we,
    input  logic [msbs_pkg::CFG_W-1:0]    i_cfg_wdata
);

    msbs_pkg::t_op_word head;
    msbs_pkg::t_result  result;
    logic               head_empty;
    logic               head_pop;
    logic               busy;

    msbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_hold         (busy),
        .i_cmd          (i_cmd),
        .i_nozzle       (i_nozzle),
        .i_element_kind (i_element_kind),
        .i_sync_id      (i_sync_id),
        .i_payload      (i_payload),
        .o_head         (head),
        .o_empty        (head_empty),
        .i_pop          (head_pop)
    );

    msbs_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .o_busy       (busy),
        .o_result     (result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_yield_valid   = result.yield_valid;
    assign o_yield_nozzle  = result.yield_nozzle;
    assign o_yield_payload = result.yield_payload;
    assign o_want_mask     = result.want_mask;
    assign o_all_done      = result.all_done;
    assign o_feed_rejected = result.feed_rejected;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input not held off during map clearing");

    a_no_yield_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_yield_valid) |-> (o_yield_payload == '0 && o_yield_nozzle == '0))
        else $error("yield fields set without a yield");

    a_yield_wants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_yield_valid) |-> (o_want_mask[o_yield_nozzle] && !o_feed_rejected))
        else $error("yielded nozzle not wanting data");

    a_done_no_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_all_done) |-> (o_want_mask == '0))
        else $error("done with a nozzle still wanting");

endmodule
